[rtl/core/kda_pkg.sv]
// kda_pkg: shared constants and register index codes for the key debounce
// and auto-repeat block. No dependencies.
`default_nettype none

package kda_pkg;

  // Core sizing
  localparam int unsigned NUM_KEYS   = 4;
  localparam int unsigned COUNT_BITS = 16;

  // Field widths
  localparam int unsigned SAMPLE_W    = 4;
  localparam int unsigned CODE_W      = 4;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CMP_W       = (COUNT_BITS > DELAY_W) ? COUNT_BITS : DELAY_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRESS_LEVEL   = 3'd0,
    REG_ALLOW_MULTI   = 3'd1,
    REG_REPEAT_EN     = 3'd2,
    REG_REPEAT_ACCEL  = 3'd3,
    REG_FIRST_DELAY   = 3'd4,
    REG_REPEAT_PERIOD = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic               RST_PRESS_LEVEL   = 1'b0;
  localparam logic               RST_ALLOW_MULTI   = 1'b0;
  localparam logic               RST_REPEAT_EN     = 1'b1;
  localparam logic               RST_REPEAT_ACCEL  = 1'b1;
  localparam logic [DELAY_W-1:0] RST_FIRST_DELAY   = DELAY_W'(50);
  localparam logic [DELAY_W-1:0] RST_REPEAT_PERIOD = DELAY_W'(10);

endpackage

`default_nettype wire

[rtl/core/key_debounce_autorepeat.sv]
// key_debounce_autorepeat: keypad debounce with auto-repeat, top level.
// Depends on kda_pkg.
//
// Channel   | Dir | Handshake                   | Payload
// ----------+-----+-----------------------------+---------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata[3:0] first_sample,
//           |     |                             | tdata[7:4] second_sample
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata[3:0] key_code, [7:4] zero
// cfg       | in  | cfg_we_i (no wait)          | cfg_idx_i register, cfg_data_i
//
// Flow: one item per clock while m_axis_tready keeps the output draining. An
// accepted item lands in the input register and is evaluated there against the
// key state; its result is captured in the output register when the stage advances.
// Reset: key state, config and valid flags return to defaults, both stages empty.
// Stalls: the input stage keeps accepting while the output register is free or
// being drained; it holds only when both stages are full and m_axis_tready is low.
`default_nettype none

module key_debounce_autorepeat (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // slave side
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [kda_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // first_sample, second_sample
  // master side
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [kda_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // key_code, zero fill
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [kda_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [kda_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import kda_pkg::*;

  // Pressed when the pin equals the press level; pins beyond the field read 0.
  function automatic logic [NUM_KEYS-1:0] key_map(input logic [SAMPLE_W-1:0] raw,
                                                  input logic lvl);
    logic [NUM_KEYS-1:0] m;
    logic                pin;
    m = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      pin = 1'b0;
      if (i < SAMPLE_W) begin
        pin = raw[i];
      end
      m[i] = ~(pin ^ lvl);
    end
    return m;
  endfunction

  // ---------------- configuration registers
  logic               press_level_q, allow_multi_q, repeat_en_q, repeat_accel_q;
  logic [DELAY_W-1:0] first_delay_q, repeat_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_level_q    <= RST_PRESS_LEVEL;
      allow_multi_q    <= RST_ALLOW_MULTI;
      repeat_en_q      <= RST_REPEAT_EN;
      repeat_accel_q   <= RST_REPEAT_ACCEL;
      first_delay_q    <= RST_FIRST_DELAY;
      repeat_period_q  <= RST_REPEAT_PERIOD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PRESS_LEVEL:   press_level_q   <= cfg_data_i[0];
        REG_ALLOW_MULTI:   allow_multi_q   <= cfg_data_i[0];
        REG_REPEAT_EN:     repeat_en_q     <= cfg_data_i[0];
        REG_REPEAT_ACCEL:  repeat_accel_q  <= cfg_data_i[0];
        REG_FIRST_DELAY:   first_delay_q   <= cfg_data_i[DELAY_W-1:0];
        REG_REPEAT_PERIOD: repeat_period_q <= cfg_data_i[DELAY_W-1:0];
        default: ;  // unlisted index: ignored
      endcase
    end
  end

  // ---------------- pipeline control
  logic in_valid_q, out_valid_q;
  logic advance;   // input stage may move into the output register
  logic accept_in;

  assign advance       = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~in_valid_q | advance;
  assign accept_in     = s_axis_tvalid & s_axis_tready;

  // ---------------- input register
  logic [SAMPLE_W-1:0] first_q, second_q;

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      first_q  <= s_axis_tdata[SAMPLE_W-1:0];
      second_q <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
  end

  // ---------------- key state
  logic [NUM_KEYS-1:0]   last_keys_q, last_keys_d;
  logic [COUNT_BITS-1:0] hold_q, hold_d;
  logic                  fast_q, fast_d;

  logic [NUM_KEYS-1:0]   map_a, map_b, code;
  logic [COUNT_BITS-1:0] hold_inc;
  logic [DELAY_W-1:0]    limit;
  logic                  single_ok;

  assign map_a     = key_map(first_q, press_level_q);
  assign map_b     = key_map(second_q, press_level_q);
  assign single_ok = allow_multi_q | $onehot(map_a);
  assign hold_inc  = (&hold_q) ? hold_q : hold_q + 1'b1;  // saturating
  assign limit     = fast_q ? repeat_period_q : first_delay_q;

  always_comb begin
    last_keys_d = last_keys_q;
    hold_d      = hold_q;
    fast_d      = fast_q;
    code        = '0;
    if (map_a != map_b) begin
      hold_d = '0;                    // bouncing
    end else if (map_a == '0) begin
      last_keys_d = '0;               // release
      hold_d      = '0;
      fast_d      = 1'b0;
    end else if (map_a != last_keys_q) begin
      last_keys_d = map_a;            // new pattern
      hold_d      = '0;
      if (single_ok) begin
        code = map_a;
      end
    end else if (!single_ok || !repeat_en_q) begin
      hold_d = '0;
    end else begin
      hold_d = hold_inc;
      if (CMP_W'(hold_inc) > CMP_W'(limit)) begin
        hold_d = '0;
        code   = map_a;
        if (repeat_accel_q) begin
          fast_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_keys_q <= '0;
      hold_q      <= '0;
      fast_q      <= 1'b0;
    end else if (in_valid_q && advance) begin
      last_keys_q <= last_keys_d;
      hold_q      <= hold_d;
      fast_q      <= fast_d;
    end
  end

  // ---------------- result register
  logic [CODE_W-1:0] key_code_d, key_code_q;

  always_comb begin
    key_code_d = '0;
    for (int i = 0; i < CODE_W; i++) begin
      if (i < NUM_KEYS) begin
        key_code_d[i] = code[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      key_code_q <= key_code_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-CODE_W)'(0), key_code_q};

endmodule

`default_nettype wire

[rtl/core/kda_checker.sv]
// kda_checker: port-level checks on key_debounce_autorepeat, bound to the top.
// Depends on kda_pkg.
`default_nettype none

module kda_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic [kda_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [kda_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                             cfg_we_i,
  input wire logic [kda_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input wire logic [kda_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import kda_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // the input side only stalls when the output holds a result and the sink stalls
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

  // fill bits above key_code stay zero
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:CODE_W] == '0)
    else $error("nonzero fill bits in result");

  // no result can exist on the first edge out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result present right after reset");

endmodule

bind key_debounce_autorepeat kda_checker u_kda_checker (.*);

`default_nettype wire

[tb/tb_key_debounce_autorepeat.sv]
// tb_key_debounce_autorepeat: self-checking bench for the keypad debounce and
// auto-repeat block. It predicts every key code and checks each output item.
// Depends on kda_pkg and the key_debounce_autorepeat RTL.
`default_nettype none

module tb_key_debounce_autorepeat;
  import kda_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int TIMEOUT_CYCLES = 3_000_000;
  localparam int DRAIN_LIMIT    = 1000;

  // Indexes outside the register map; writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(7);

  // ---------------------------------------------------------------------------
  // DUT ports; the inputs are driven to known values from time zero
  // ---------------------------------------------------------------------------
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // first_sample, second_sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // key_code, zero fill
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = REG_PRESS_LEVEL;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  key_debounce_autorepeat DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copy and key state
  // ---------------------------------------------------------------------------
  logic                  sh_press_level   = RST_PRESS_LEVEL;
  logic                  sh_allow_multi   = RST_ALLOW_MULTI;
  logic                  sh_repeat_en     = RST_REPEAT_EN;
  logic                  sh_repeat_accel  = RST_REPEAT_ACCEL;
  logic [DELAY_W-1:0]    sh_first_delay   = RST_FIRST_DELAY;
  logic [DELAY_W-1:0]    sh_repeat_period = RST_REPEAT_PERIOD;

  logic [NUM_KEYS-1:0]   held_keys  = '0;   // remembered pattern
  logic [COUNT_BITS-1:0] hold_scans = '0;   // scans the pattern has been held
  logic                  fast_mode  = 1'b0; // repeat period is the limit

  // Key codes still owed by the block, oldest first
  logic [CODE_W-1:0] pending_codes[$];

  // Bench knobs and tallies
  bit tx_gaps_on    = 1'b0;
  bit rx_stalls_on  = 1'b0;
  int rx_holdoff    = 0;
  int rx_stall_left = 0;
  int n_fail        = 0;
  int n_scans       = 0;
  int n_checked     = 0;
  int n_reports     = 0;
  int n_cfg_writes  = 0;

  // Pressed-key map for one raw sample under the current press level
  function automatic logic [NUM_KEYS-1:0] pressed_of(input logic [SAMPLE_W-1:0] raw);
    return sh_press_level ? raw[NUM_KEYS-1:0] : ~raw[NUM_KEYS-1:0];
  endfunction

  // Raw pin levels that show exactly the given keys pressed
  function automatic logic [SAMPLE_W-1:0] raw_of(input logic [NUM_KEYS-1:0] keys);
    return sh_press_level ? SAMPLE_W'(keys) : SAMPLE_W'(~keys);
  endfunction

  // Debounce / auto-repeat decision for one scan; updates the key state
  function automatic logic [CODE_W-1:0] debounce_scan(input logic [SAMPLE_W-1:0] raw1,
                                                      input logic [SAMPLE_W-1:0] raw2);
    logic [NUM_KEYS-1:0] a;
    logic [NUM_KEYS-1:0] b;
    logic [DELAY_W-1:0]  limit;
    logic [CODE_W-1:0]   code;
    a    = pressed_of(raw1);
    b    = pressed_of(raw2);
    code = '0;
    if (a != b) begin
      // bouncing: restart the hold count only
      hold_scans = '0;
    end else if (a == '0) begin
      held_keys  = '0;
      hold_scans = '0;
      fast_mode  = 1'b0;
    end else if (a != held_keys) begin
      hold_scans = '0;
      held_keys  = a;
      if (sh_allow_multi || $countones(a) == 1) code = CODE_W'(a);
    end else if (!sh_allow_multi && $countones(a) != 1) begin
      hold_scans = '0;
    end else if (!sh_repeat_en) begin
      hold_scans = '0;
    end else begin
      limit = fast_mode ? sh_repeat_period : sh_first_delay;
      if (hold_scans != '1) hold_scans++;
      if (hold_scans > limit) begin
        hold_scans = '0;
        if (sh_repeat_accel) fast_mode = 1'b1;
        code = CODE_W'(a);
      end
    end
    return code;
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_PRESS_LEVEL:   sh_press_level   = val[0];
      REG_ALLOW_MULTI:   sh_allow_multi   = val[0];
      REG_REPEAT_EN:     sh_repeat_en     = val[0];
      REG_REPEAT_ACCEL:  sh_repeat_accel  = val[0];
      REG_FIRST_DELAY:   sh_first_delay   = val[DELAY_W-1:0];
      REG_REPEAT_PERIOD: sh_repeat_period = val[DELAY_W-1:0];
      default: ;
    endcase
  endfunction

  // Idle lengths: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one scan item and hold it until accepted; returns on the accepting edge
  task automatic send_scan(input logic [SAMPLE_W-1:0] raw1, input logic [SAMPLE_W-1:0] raw2);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {raw2, raw1};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_codes.push_back(debounce_scan(raw1, raw2));
    n_scans++;
  endtask

  task automatic press_scan(input logic [NUM_KEYS-1:0] keys);
    send_scan(raw_of(keys), raw_of(keys));
  endtask

  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  task automatic maybe_gap();
    if (tx_gaps_on) idle_for(pick_gap());
  endtask

  // Stop offering and wait until every owed key code has come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    // two-stage pipe is empty once the last code has left
    repeat (2) @(negedge clk_i);
  endtask

  // Register write, only with the block idle
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    apply_setting(idx, val);
    n_cfg_writes++;
  endtask

  task automatic cfg_all(input logic press, input logic multi, input logic en,
                         input logic accel, input logic [DELAY_W-1:0] first_dly,
                         input logic [DELAY_W-1:0] period);
    cfg_write(REG_PRESS_LEVEL,   CFG_DATA_W'(press));
    cfg_write(REG_ALLOW_MULTI,   CFG_DATA_W'(multi));
    cfg_write(REG_REPEAT_EN,     CFG_DATA_W'(en));
    cfg_write(REG_REPEAT_ACCEL,  CFG_DATA_W'(accel));
    cfg_write(REG_FIRST_DELAY,   CFG_DATA_W'(first_dly));
    cfg_write(REG_REPEAT_PERIOD, CFG_DATA_W'(period));
  endtask

  // Mostly well-formed press / hold / release runs with random content,
  // the rest bouncing scans and raw noise
  task automatic random_scans(input int n_items);
    int                  sent;
    int                  cap;
    int                  hold_len;
    logic [NUM_KEYS-1:0] keys;
    logic [SAMPLE_W-1:0] raw;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 9) < 6) keys = NUM_KEYS'(1) << $urandom_range(0, NUM_KEYS - 1);
        else keys = NUM_KEYS'($urandom_range(1, (1 << NUM_KEYS) - 1));
        cap = (sh_first_delay > sh_repeat_period) ? int'(sh_first_delay) : int'(sh_repeat_period);
        hold_len = $urandom_range(1, 3 * cap + 5);
        repeat (hold_len) begin
          raw = raw_of(keys);
          // occasional bounce in the middle of a hold
          if ($urandom_range(0, 19) == 0)
            send_scan(raw, raw ^ SAMPLE_W'($urandom_range(1, 15)));
          else
            send_scan(raw, raw);
          sent++;
          maybe_gap();
        end
        if ($urandom_range(0, 1)) begin
          press_scan('0);
          sent++;
          maybe_gap();
        end
      end else begin
        raw = SAMPLE_W'($urandom_range(0, 15));
        send_scan(raw, $urandom_range(0, 1) ? raw : SAMPLE_W'($urandom_range(0, 15)));
        sent++;
        maybe_gap();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, or a long counted hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rx_holdoff > 0) begin
      rx_holdoff--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
      rx_stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every accepted output item is matched against the oldest owed key code
  always @(posedge clk_i) begin : check_codes
    logic [CODE_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected item: key_code %0h", m_axis_tdata[CODE_W-1:0]);
        n_fail++;
      end else begin
        want = pending_codes.pop_front();
        n_checked++;
        if (want != '0) n_reports++;
        if (m_axis_tdata[CODE_W-1:0] !== want) begin
          $error("key_code mismatch: expected %0h actual %0h", want, m_axis_tdata[CODE_W-1:0]);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short hand-picked walk through every decision path, small delays
  task automatic test_directed_scans();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    // unmapped indexes: must be ignored
    cfg_write(REG_SPARE_A, '1);
    cfg_write(REG_SPARE_B, '1);
    cfg_write(REG_FIRST_DELAY,   CFG_DATA_W'(2));
    cfg_write(REG_REPEAT_PERIOD, CFG_DATA_W'(1));
    // press level low, single-key mode
    press_scan('0);                               // all released
    send_scan(raw_of(4'h1), raw_of(4'h0));        // samples differ
    press_scan(4'h1);                             // new single key, reported
    repeat (3) press_scan(4'h1);                  // first repeat after first delay
    repeat (2) press_scan(4'h1);                  // accelerated repeat
    send_scan(raw_of(4'h1), raw_of(4'h3));        // bounce while held
    repeat (2) press_scan(4'h1);
    press_scan(4'h3);                             // combination, single mode: silent
    press_scan(4'h3);                             // held combination
    press_scan(4'h8);                             // fast flag survives a new key
    press_scan(4'hF);                             // every key
    press_scan('0);
    // press level high, combinations reported
    cfg_write(REG_PRESS_LEVEL, CFG_DATA_W'(1));
    cfg_write(REG_ALLOW_MULTI, CFG_DATA_W'(1));
    press_scan(4'hF);
    repeat (2) press_scan(4'hF);
    press_scan('0);
    press_scan(4'hA);
    send_scan(4'hA, 4'h5);                        // fully opposite samples
    press_scan('0);
    // repeat off: held key stays quiet
    cfg_write(REG_REPEAT_EN, CFG_DATA_W'(0));
    repeat (4) press_scan(4'h2);
    press_scan('0);
    drain();
  endtask

  // Output held off long enough for the pipe to fill and stall the input
  task automatic test_output_backpressure();
    cfg_all(1'b0, 1'b1, 1'b1, 1'b1, DELAY_W'(1), DELAY_W'(0));
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    @(posedge clk_i);
    rx_holdoff = 150;
    repeat (8) press_scan(4'h6);
    press_scan('0);
    random_scans(40);
    // sender pauses until every owed code is out
    drain();
  endtask

  // One register setting, then random runs with gaps and stalls on both sides
  task automatic test_random_phase(input int phase, input int n_items);
    logic [DELAY_W-1:0] first_dly;
    logic [DELAY_W-1:0] period;
    first_dly = (phase == 0) ? '0 : (phase == 7) ? DELAY_W'(12) : DELAY_W'($urandom_range(0, 10));
    period    = (phase == 1) ? '0 : (phase == 3) ? DELAY_W'(12) : DELAY_W'($urandom_range(0, 6));
    cfg_all(phase[0], phase[1], phase != 6, phase[2], first_dly, period);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = (phase != 4);  // one phase runs with the receiver always ready
    random_scans(n_items);
    drain();
  endtask

  // Longer delays: one key held through the first repeat and two fast ones
  task automatic test_long_hold();
    cfg_all(1'b1, 1'b0, 1'b1, 1'b1, DELAY_W'(150), DELAY_W'(60));
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    press_scan('0);
    repeat (300) press_scan(4'h4);
    press_scan('0);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    int waited;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_scans();
    test_output_backpressure();
    for (int p = 0; p < 8; p++) test_random_phase(p, 100);
    test_long_hold();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_codes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_codes.size() != 0) begin
      $error("%0d key codes never came out", pending_codes.size());
      n_fail++;
    end
    repeat (4) @(posedge clk_i);

    $display("Run: %0d scans sent, %0d key codes checked, %0d of them reports,",
             n_scans, n_checked, n_reports);
    $display("     %0d register writes over 8 random settings plus directed and long-hold runs",
             n_cfg_writes);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/kda_pkg.sv
rtl/core/key_debounce_autorepeat.sv
rtl/core/kda_checker.sv
tb/tb_key_debounce_autorepeat.sv
